[rtl/fbc_pkg.sv]
// fbc_pkg: shared types, sizes and codes for the free block coalescer
// depends on nothing; imported by every module of the block

package fbc_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // field widths fixed by the interface
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 33;
  localparam int CNT_OUT_W   = 9;
  localparam int INDEX_W     = 8;

  // operation codes
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_MERGE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // request item
  typedef struct packed {
    logic [1:0]         func;
    logic [ADDR_W-1:0]  block_start;
    logic [ADDR_W-1:0]  block_size;
    logic [INDEX_W-1:0] entry_index;
  } req_t;

  // result item
  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [ADDR_W-1:0]    entry_start;
    logic [LEN_W-1:0]     entry_size;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  size;
  } tbl_entry_t;

  // table access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    tbl_entry_t       wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

  // current span held by the sequencer
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [LEN_W-1:0]  hi;
  } span_op_t;

  // span unit results
  typedef struct packed {
    logic [LEN_W-1:0]  ent_hi;
    logic              overlap;
    logic [ADDR_W-1:0] new_lo;
    logic [LEN_W-1:0]  new_hi;
    logic [LEN_W-1:0]  len;
  } span_res_t;

endpackage

[rtl/fbc_table.sv]
// fbc_table: block table memory, one write port and one registered read port
// depends on fbc_pkg

module fbc_table import fbc_pkg::*; (
  input  logic       clk,
  input  tbl_req_t   tbl,
  output tbl_entry_t rd_data
);

  tbl_entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (tbl.we) begin
      mem[tbl.waddr] <= tbl.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[tbl.raddr];
  end

endmodule

[rtl/fbc_span_unit.sv]
// fbc_span_unit: shared add and compare unit for block ends and overlap tests
// depends on fbc_pkg

module fbc_span_unit import fbc_pkg::*; (
  input  span_op_t   op,
  input  tbl_entry_t ent,
  output span_res_t  res
);

  logic [LEN_W-1:0] lo_ext;
  logic [LEN_W-1:0] ent_lo;

  assign lo_ext = {1'b0, op.lo};
  assign ent_lo = {1'b0, ent.start};

  // end of the entry, exclusive
  assign res.ent_hi = ent_lo + ent.size;

  // overlap or touch test
  assign res.overlap = !((ent_lo > op.hi) || (res.ent_hi < lo_ext));

  // widened span
  assign res.new_lo = (ent.start < op.lo) ? ent.start : op.lo;
  assign res.new_hi = (res.ent_hi > op.hi) ? res.ent_hi : op.hi;

  // merged length
  assign res.len = op.hi - lo_ext;

endmodule

[rtl/fbc_ctrl.sv]
// fbc_ctrl: sequencer for add, read and the coalescing scan over the table
// depends on fbc_pkg; drives fbc_table and fbc_span_unit

module fbc_ctrl import fbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output tbl_req_t   tbl,
  input  tbl_entry_t rd_data,
  output span_op_t   op,
  input  span_res_t  span,
  output logic       res_valid,
  input  logic       res_ready,
  output rsp_t       res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD_LD = 4'd1;
  localparam logic [3:0] S_I_RD  = 4'd2;
  localparam logic [3:0] S_I_LD  = 4'd3;
  localparam logic [3:0] S_J_RD  = 4'd4;
  localparam logic [3:0] S_J_CMP = 4'd5;
  localparam logic [3:0] S_J_MOV = 4'd6;
  localparam logic [3:0] S_I_END = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  logic [3:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  i_idx, i_idx_next;
  logic [CNT_W-1:0]  j_idx, j_idx_next;
  logic [ADDR_W-1:0] lo, lo_next;
  logic [LEN_W-1:0]  hi, hi_next;
  logic              joined, joined_next;
  logic [1:0]        pend_status, pend_status_next;
  logic [ADDR_W-1:0] pend_start, pend_start_next;
  logic [LEN_W-1:0]  pend_size, pend_size_next;
  logic [CNT_W-1:0]  last_idx;

  assign last_idx = count - ONE_CNT;
  assign op.lo    = lo;
  assign op.hi    = hi;

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  assign res.status      = pend_status;
  assign res.entry_count = CNT_OUT_W'(count);
  assign res.entry_start = pend_start;
  assign res.entry_size  = pend_size;

  // next state and table access
  always_comb begin
    state_next       = state;
    count_next       = count;
    i_idx_next       = i_idx;
    j_idx_next       = j_idx;
    lo_next          = lo;
    hi_next          = hi;
    joined_next      = joined;
    pend_status_next = pend_status;
    pend_start_next  = pend_start;
    pend_size_next   = pend_size;
    tbl.we           = 1'b0;
    tbl.waddr        = i_idx[IDX_W-1:0];
    tbl.wdata        = rd_data;
    tbl.raddr        = i_idx[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          pend_status_next = ST_OK;
          pend_start_next  = '0;
          pend_size_next   = '0;
          unique case (req.func)
            FUNC_ADD: begin
              if (count >= DEPTH_CNT) begin
                pend_status_next = ST_FULL;
              end else begin
                tbl.we          = 1'b1;
                tbl.waddr       = count[IDX_W-1:0];
                tbl.wdata.start = req.block_start;
                tbl.wdata.size  = {1'b0, req.block_size};
                count_next      = count + ONE_CNT;
              end
              state_next = S_DONE;
            end
            FUNC_MERGE: begin
              i_idx_next = '0;
              state_next = S_I_RD;
            end
            FUNC_READ: begin
              if (32'(req.entry_index) >= 32'(count)) begin
                pend_status_next = ST_RANGE;
                state_next       = S_DONE;
              end else begin
                tbl.raddr  = IDX_W'(req.entry_index);
                state_next = S_RD_LD;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      // read data back for a read item
      S_RD_LD: begin
        pend_start_next = rd_data.start;
        pend_size_next  = rd_data.size;
        state_next      = S_DONE;
      end
      // fetch entry i or finish the merge
      S_I_RD: begin
        if (i_idx >= count) begin
          state_next = S_DONE;
        end else begin
          tbl.raddr  = i_idx[IDX_W-1:0];
          state_next = S_I_LD;
        end
      end
      S_I_LD: begin
        lo_next     = rd_data.start;
        hi_next     = span.ent_hi;
        joined_next = 1'b0;
        j_idx_next  = i_idx + ONE_CNT;
        state_next  = S_J_RD;
      end
      // fetch entry j or close the pass
      S_J_RD: begin
        if (j_idx >= count) begin
          state_next = S_I_END;
        end else begin
          tbl.raddr  = j_idx[IDX_W-1:0];
          state_next = S_J_CMP;
        end
      end
      // test j against the span, fetch the last entry on a join
      S_J_CMP: begin
        if (!span.overlap) begin
          j_idx_next = j_idx + ONE_CNT;
          state_next = S_J_RD;
        end else begin
          lo_next     = span.new_lo;
          hi_next     = span.new_hi;
          joined_next = 1'b1;
          tbl.raddr   = last_idx[IDX_W-1:0];
          state_next  = S_J_MOV;
        end
      end
      // move the last entry into slot j and rescan j
      S_J_MOV: begin
        tbl.we     = 1'b1;
        tbl.waddr  = j_idx[IDX_W-1:0];
        tbl.wdata  = rd_data;
        count_next = last_idx;
        state_next = S_J_RD;
      end
      // write back the merged span and rescan i, or advance
      S_I_END: begin
        if (joined) begin
          tbl.we          = 1'b1;
          tbl.waddr       = i_idx[IDX_W-1:0];
          tbl.wdata.start = lo;
          tbl.wdata.size  = span.len;
        end else begin
          i_idx_next = i_idx + ONE_CNT;
        end
        state_next = S_I_RD;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i_idx       <= i_idx_next;
    j_idx       <= j_idx_next;
    lo          <= lo_next;
    hi          <= hi_next;
    joined      <= joined_next;
    pend_status <= pend_status_next;
    pend_start  <= pend_start_next;
    pend_size   <= pend_size_next;
  end

endmodule

[rtl/free_block_coalescer_top.sv]
// Add and unused codes go to S_DONE; a read first loads the entry in S_RD_LD.
// Merge time is set by the single table read port and the shared span unit;
// worst case on the order of N*N pair compares for N entries. One item at a time.
// Reset clears the entry count and control; table contents are not cleared.
// Result sits in an output register, so a new item is taken while it waits.

module free_block_coalescer_top import fbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  tbl_req_t   tbl;
  tbl_entry_t rd_data;
  span_op_t   op;
  span_res_t  span;
  logic       res_valid;
  logic       res_ready;
  rsp_t       res;

  fbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .tbl       (tbl),
    .rd_data   (rd_data),
    .op        (op),
    .span      (span),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  fbc_table u_table (
    .clk     (clk),
    .tbl     (tbl),
    .rd_data (rd_data)
  );

  fbc_span_unit u_span (
    .op  (op),
    .ent (rd_data),
    .res (span)
  );

  // output register
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

[rtl/fbc_checker.sv]
// fbc_checker: port-level checks on the coalescer item streams
// depends on fbc_pkg; bound to free_block_coalescer_top

module fbc_checker import fbc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // stalled request holds
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // full flag only with a full table
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_OUT_W'(TABLE_DEPTH))
    else $error("full status with table not full");

  // entry fields zero unless status is ok
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.entry_start == '0 && rsp.entry_size == '0)
    else $error("entry data on a failed item");

  // count never beyond depth
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_count <= CNT_OUT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind free_block_coalescer_top fbc_checker u_fbc_checker (.*);
